// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the strip stitch checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define SRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/srds_pkg.sv =====
// ----------------------------------------------------------------------------
// srds_pkg
// Types and constants shared by the strip restart stitch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srds_pkg;

    localparam int unsigned IDX_W = 32;

    localparam logic [IDX_W-1:0] RESTART_RESET = 32'h0000_ffff;
    localparam logic [1:0]       LEAD_FULL     = 2'd2;

    typedef logic [IDX_W-1:0] t_index;

    // result load from the stitch core into the output buffer
    typedef struct packed {
        logic   load;
        t_index index;
        logic   twice;
    } t_load;

endpackage

`default_nettype wire

// ===== design/srds_chan_if.sv =====
// ----------------------------------------------------------------------------
// srds_chan_if
// Valid/ready channel interfaces: input items, result items, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface srds_in_if;
    logic                valid;
    logic                ready;
    srds_pkg::t_index    index_value;
    logic                final_item;

    modport source (output valid, output index_value, output final_item, input ready);
    modport sink   (input valid, input index_value, input final_item, output ready);
endinterface

interface srds_out_if;
    logic                valid;
    logic                ready;
    srds_pkg::t_index    out_index;
    logic                run_end;

    modport source (output valid, output out_index, output run_end, input ready);
    modport sink   (input valid, input out_index, input run_end, output ready);
endinterface

interface srds_cfg_if;
    logic                valid;
    logic                ready;
    srds_pkg::t_index    restart_value;

    modport source (output valid, output restart_value, input ready);
    modport sink   (input valid, input restart_value, output ready);
endinterface

`default_nettype wire

// ===== design/srds_stitch_core.sv =====
// ----------------------------------------------------------------------------
// srds_stitch_core
// Strip state and restart decode; yields up to two results per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module srds_stitch_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire srds_pkg::t_index  i_index_value,
    input  wire logic              i_final_item,
    input  wire logic              i_cfg_write,
    input  wire srds_pkg::t_index  i_cfg_value,
    output srds_pkg::t_load        o_load
);

    srds_pkg::t_index r_restart_value;
    srds_pkg::t_index r_previous_index, n_previous_index;
    logic [1:0]       r_lead_count, n_lead_count;
    logic             r_odd_parity, n_odd_parity;
    logic             r_restart_pending, n_restart_pending;

    logic is_restart;

    assign is_restart = (i_index_value == r_restart_value);

    always_comb begin
        n_previous_index  = r_previous_index;
        n_lead_count      = r_lead_count;
        n_odd_parity      = r_odd_parity;
        n_restart_pending = r_restart_pending;
        o_load            = '0;
        o_load.index      = i_index_value;

        if (r_lead_count < srds_pkg::LEAD_FULL) begin
            o_load.load      = 1'b1;
            n_previous_index = i_index_value;
            n_lead_count     = r_lead_count + 2'd1;
        end else if (is_restart) begin
            if (!r_restart_pending && !i_final_item) begin
                o_load.load       = 1'b1;
                o_load.index      = r_previous_index;
                o_load.twice      = r_odd_parity;
                n_odd_parity      = 1'b0;
                n_restart_pending = 1'b1;
            end
        end else if (r_restart_pending) begin
            o_load.load       = 1'b1;
            o_load.twice      = 1'b1;
            n_odd_parity      = 1'b1;
            n_restart_pending = 1'b0;
            n_previous_index  = i_index_value;
        end else begin
            o_load.load      = 1'b1;
            n_odd_parity     = ~r_odd_parity;
            n_previous_index = i_index_value;
        end

        // start a new buffer after the final item
        if (i_final_item) begin
            n_previous_index  = '0;
            n_lead_count      = '0;
            n_odd_parity      = 1'b0;
            n_restart_pending = 1'b0;
        end

        o_load.load = o_load.load & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restart_value   <= srds_pkg::RESTART_RESET;
            r_previous_index  <= '0;
            r_lead_count      <= '0;
            r_odd_parity      <= 1'b0;
            r_restart_pending <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_restart_value <= i_cfg_value;
            end
            if (i_accept) begin
                r_previous_index  <= n_previous_index;
                r_lead_count      <= n_lead_count;
                r_odd_parity      <= n_odd_parity;
                r_restart_pending <= n_restart_pending;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/srds_out_buf.sv =====
// ----------------------------------------------------------------------------
// srds_out_buf
// Result register; replays a doubled index and flags the last result.
// ----------------------------------------------------------------------------
`default_nettype none

module srds_out_buf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srds_pkg::t_load i_load,
    output logic                 o_space,
    srds_out_if.source           o_out_chan
);

    logic             r_valid;
    logic             r_twice;
    srds_pkg::t_index r_index;
    logic             out_take;

    assign out_take   = r_valid && o_out_chan.ready;
    assign o_space    = !r_valid || (!r_twice && o_out_chan.ready);

    assign o_out_chan.valid     = r_valid;
    assign o_out_chan.out_index = r_index;
    assign o_out_chan.run_end   = !r_twice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_twice <= 1'b0;
        end else if (i_load.load) begin
            r_valid <= 1'b1;
            r_twice <= i_load.twice;
        end else if (out_take) begin
            // drop the repeat first, then the item
            if (r_twice) begin
                r_twice <= 1'b0;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_index <= i_load.index;
        end
    end

endmodule

`default_nettype wire

// ===== design/strip_restart_to_degenerate_stitch_unit.sv =====
// ----------------------------------------------------------------------------
// strip_restart_to_degenerate_stitch_unit
// Joins restart-separated triangle strips into one strip of degenerate joins.
// ----------------------------------------------------------------------------
// One index is accepted per cycle while the buffer has space. An item with
// one result passes straight through the single result register, so a
// steady stream moves at one item per cycle while output is ready. An item
// with two results (odd-parity restart or the first index after a restart)
// blocks input until its repeat is taken. Items with no result only update
// the strip state. The restart value resets to 0xffff and may be rewritten
// at any time the block is idle; the write channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_restart_to_degenerate_stitch_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srds_in_if.sink    i_in_chan,
    srds_cfg_if.sink   i_cfg_chan,
    srds_out_if.source o_out_chan
);

    srds_pkg::t_load load;
    logic            space;
    logic            accept;

    assign i_in_chan.ready  = space;
    assign i_cfg_chan.ready = 1'b1;
    assign accept           = i_in_chan.valid && space;

    srds_stitch_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_index_value (i_in_chan.index_value),
        .i_final_item  (i_in_chan.final_item),
        .i_cfg_write   (i_cfg_chan.valid),
        .i_cfg_value   (i_cfg_chan.restart_value),
        .o_load        (load)
    );

    srds_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .o_space    (space),
        .o_out_chan (o_out_chan)
    );

endmodule

`default_nettype wire

// ===== design/srds_checker.sv =====
// ----------------------------------------------------------------------------
// srds_checker
// Port-level checks on the strip stitch unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srds_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire srds_pkg::t_index i_out_index,
    input wire logic             i_out_run_end
);

    `SRDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_index) && $stable(i_out_run_end))

    `SRDS_ASSERT_NEXT(a_repeat_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_run_end, i_out_valid && i_out_index == $past(i_out_index) && i_out_run_end)

    `SRDS_ASSERT_IMPLY(a_stall_blocks_in, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)

    `SRDS_ASSERT_IMPLY(a_empty_takes_in, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind strip_restart_to_degenerate_stitch_unit srds_checker u_srds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in_chan.ready),
    .i_out_valid   (o_out_chan.valid),
    .i_out_ready   (o_out_chan.ready),
    .i_out_index   (o_out_chan.out_index),
    .i_out_run_end (o_out_chan.run_end)
);

`default_nettype wire
